FILE: hdl/mxs_pkg.sv
// shared constants and queue entry type for the max-sum mountain block
// no dependencies
package mxs_pkg;
   localparam int MAX_LEN_DEF     = 64;
   localparam int HEIGHT_BITS_DEF = 32;
   localparam int LIMIT_W         = 32;
   localparam int SUM_W           = 40;
   localparam int POS_W           = 6;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic               last;
   } queue_entry_type;
endpackage

FILE: hdl/mxs_front.sv
// front end: accepts limits, marks the last of a sequence, queues them
// depends on mxs_pkg
module mxs_front import mxs_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [LIMIT_W-1:0]  req_limit,
   input  logic                req_is_final,
   output logic                q_valid,
   input  logic                q_ready,
   output queue_entry_type     q_data
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   queue_entry_type  slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop, last;

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign last      = req_is_final || (cnt_ff == CNT_W'(MAX_LEN - 1));

   always_comb begin
      cnt_in    = cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         cnt_in    = last ? '0 : cnt_ff + 1'b1;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{limit: req_limit, last: last};
      end
   end
endmodule

FILE: hdl/mxs_back.sv
// back end: stack passes, peak search, height fill and result output
// depends on mxs_pkg
module mxs_back import mxs_pkg::*; #(
   parameter int MAX_LEN     = MAX_LEN_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  queue_entry_type     q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LIMIT_W-1:0]  rsp_height,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_run_end
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int HB    = HEIGHT_BITS;
   localparam int MUL_W = CNT_W + HB;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_POP  = 4'd1;
   localparam logic [3:0] S_TOP  = 4'd2;
   localparam logic [3:0] S_CMP  = 4'd3;
   localparam logic [3:0] S_CALC = 4'd4;
   localparam logic [3:0] S_WR   = 4'd5;
   localparam logic [3:0] S_BLD  = 4'd6;
   localparam logic [3:0] S_BA   = 4'd7;
   localparam logic [3:0] S_CRD  = 4'd8;
   localparam logic [3:0] S_CEV  = 4'd9;
   localparam logic [3:0] S_HRD  = 4'd10;
   localparam logic [3:0] S_HWR  = 4'd11;
   localparam logic [3:0] S_ERD  = 4'd12;
   localparam logic [3:0] S_EOUT = 4'd13;

   logic [HB-1:0]    lim_mem   [MAX_LEN];
   logic [SUM_W-1:0] left_mem  [MAX_LEN];
   logic [SUM_W-1:0] right_mem [MAX_LEN];
   logic [IDX_W-1:0] stk_mem   [MAX_LEN];
   logic [HB-1:0]    hgt_mem   [MAX_LEN];

   logic [HB-1:0]    lim_rd_ff, hgt_rd_ff;
   logic [SUM_W-1:0] left_rd_ff, right_rd_ff;
   logic [IDX_W-1:0] stk_rd_ff;

   logic [3:0]       state_ff, state_in;
   logic             dir_ff, dir_in, side_ff, side_in, last_ff, last_in;
   logic [IDX_W-1:0] cur_ff, cur_in, top_ff, top_in, peak_ff, peak_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_ff, n_in, depth_ff, depth_in;
   logic [HB-1:0]    val_ff, val_in, run_ff, run_in, pkh_ff, pkh_in;
   logic [SUM_W-1:0] base_ff, base_in, prod_ff, prod_in, best_ff, best_in;

   logic [IDX_W-1:0] ra, stk_ra;
   logic [CNT_W-1:0] mop, depth_m1;
   logic [MUL_W-1:0] mul_w;
   logic [SUM_W-1:0] sum_w, tot_w;
   logic [HB-1:0]    min_w;
   logic             cur_is_end;

   assign depth_m1   = depth_ff - 1'b1;
   assign stk_ra     = depth_m1[IDX_W-1:0];
   assign ra         = (state_ff == S_TOP) ? stk_rd_ff : cur_ff;
   assign cur_is_end = ((CNT_W'(cur_ff) + 1'b1) == n_ff);
   assign sum_w      = prod_ff + base_ff;
   assign tot_w      = left_rd_ff + right_rd_ff - SUM_W'(lim_rd_ff);
   assign min_w      = (lim_rd_ff < run_ff) ? lim_rd_ff : run_ff;
   assign mul_w      = MUL_W'(mop) * MUL_W'(val_ff);

   assign q_ready      = (state_ff == S_IDLE);
   assign rsp_valid    = (state_ff == S_EOUT);
   assign rsp_height   = LIMIT_W'(hgt_rd_ff);
   assign rsp_position = POS_W'(cur_ff);
   assign rsp_run_end  = cur_is_end;

   always_comb begin
      if (depth_ff != '0) begin
         mop = dir_ff ? CNT_W'(top_ff - cur_ff) : CNT_W'(cur_ff - top_ff);
      end else begin
         mop = dir_ff ? (n_ff - CNT_W'(cur_ff)) : (CNT_W'(cur_ff) + 1'b1);
      end
   end

   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      side_in  = side_ff;
      last_in  = last_ff;
      cur_in   = cur_ff;
      top_in   = top_ff;
      peak_in  = peak_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      depth_in = depth_ff;
      val_in   = val_ff;
      run_in   = run_ff;
      pkh_in   = pkh_ff;
      base_in  = base_ff;
      prod_in  = prod_ff;
      best_in  = best_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               val_in   = q_data.limit[HB-1:0];
               last_in  = q_data.last;
               cur_in   = cnt_ff[IDX_W-1:0];
               dir_in   = 1'b0;
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = (depth_ff == '0) ? S_CALC : S_TOP;
         end
         S_TOP: begin
            top_in   = stk_rd_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (lim_rd_ff > val_ff) begin
               depth_in = depth_m1;
               state_in = S_POP;
            end else begin
               base_in  = dir_ff ? right_rd_ff : left_rd_ff;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            prod_in = SUM_W'(mul_w);
            if (depth_ff == '0) begin
               base_in = '0;
            end
            state_in = S_WR;
         end
         S_WR: begin
            depth_in = depth_ff + 1'b1;
            if (!dir_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (last_ff) begin
                  n_in     = cnt_ff + 1'b1;
                  depth_in = '0;
                  dir_in   = 1'b1;
                  state_in = S_BLD;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (cur_ff == '0) begin
               state_in = S_CRD;
            end else begin
               cur_in   = cur_ff - 1'b1;
               state_in = S_BLD;
            end
         end
         S_BLD: begin
            state_in = S_BA;
         end
         S_BA: begin
            val_in   = lim_rd_ff;
            state_in = S_POP;
         end
         S_CRD: begin
            state_in = S_CEV;
         end
         S_CEV: begin
            if ((cur_ff == '0) || (tot_w > best_ff)) begin
               best_in = tot_w;
               peak_in = cur_ff;
            end
            if (cur_is_end) begin
               cur_in   = peak_in;
               run_in   = '1;
               side_in  = 1'b0;
               state_in = S_HRD;
            end else begin
               cur_in   = cur_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         S_HRD: begin
            state_in = S_HWR;
         end
         S_HWR: begin
            run_in   = min_w;
            state_in = S_HRD;
            if (!side_ff) begin
               if (cur_ff == peak_ff) begin
                  pkh_in = min_w;
               end
               if (cur_ff == '0) begin
                  if ((CNT_W'(peak_ff) + 1'b1) == n_ff) begin
                     cur_in   = '0;
                     state_in = S_ERD;
                  end else begin
                     cur_in  = peak_ff + 1'b1;
                     run_in  = (cur_ff == peak_ff) ? min_w : pkh_ff;
                     side_in = 1'b1;
                  end
               end else begin
                  cur_in = cur_ff - 1'b1;
               end
            end else if (cur_is_end) begin
               cur_in   = '0;
               state_in = S_ERD;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_ready) begin
               if (cur_is_end) begin
                  cnt_in   = '0;
                  depth_in = '0;
                  state_in = S_IDLE;
               end else begin
                  cur_in   = cur_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         depth_ff <= '0;
         best_ff  <= '0;
         peak_ff  <= '0;
         dir_ff   <= 1'b0;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         depth_ff <= depth_in;
         best_ff  <= best_in;
         peak_ff  <= peak_in;
         dir_ff   <= dir_in;
         side_ff  <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      cur_ff  <= cur_in;
      top_ff  <= top_in;
      n_ff    <= n_in;
      val_ff  <= val_in;
      run_ff  <= run_in;
      pkh_ff  <= pkh_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
   end

   // memories
   always_ff @(posedge clock) begin
      stk_rd_ff   <= stk_mem[stk_ra];
      lim_rd_ff   <= lim_mem[ra];
      left_rd_ff  <= left_mem[ra];
      right_rd_ff <= right_mem[ra];
      hgt_rd_ff   <= hgt_mem[cur_ff];
      if (state_ff == S_WR) begin
         stk_mem[depth_ff[IDX_W-1:0]] <= cur_ff;
         if (dir_ff) begin
            right_mem[cur_ff] <= sum_w;
         end else begin
            left_mem[cur_ff] <= sum_w;
            lim_mem[cur_ff]  <= val_ff;
         end
      end
      if (state_ff == S_HWR) begin
         hgt_mem[cur_ff] <= min_w;
      end
   end
endmodule

FILE: hdl/max_sum_mountain_under_limits_top.sv
// top level of the max-sum mountain block
// depends on mxs_pkg, mxs_front, mxs_back
//
// usage: send height limits on req_ (req_limit, req_is_final), one per
// transaction. the transaction with req_is_final set, or the one that fills
// MAX_LEN positions, closes the sequence. the block then returns one rsp_
// transaction per position in position order: rsp_height, rsp_position, and
// rsp_run_end on the last one.
// each limit goes through the forward stack pass. on the closing limit the
// back end runs the backward stack pass, the peak search, the height fill
// and the output, all limited by the single read port of each memory.
// a two-entry queue sits between front and back, so limits are taken while
// the back end works. if the receiver stalls, the current result holds and
// the queue fills, then req_ready drops. synchronous reset empties the queue
// and starts a new sequence.
module max_sum_mountain_under_limits_top import mxs_pkg::*; #(
   parameter int MAX_LEN     = MAX_LEN_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [LIMIT_W-1:0]  req_limit,
   input  logic                req_is_final,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LIMIT_W-1:0]  rsp_height,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_run_end
);
   logic            q_valid, q_ready;
   queue_entry_type q_data;

   mxs_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_limit    (req_limit),
      .req_is_final (req_is_final),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_data       (q_data)
   );

   mxs_back #(.MAX_LEN(MAX_LEN), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_data       (q_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_height   (rsp_height),
      .rsp_position (rsp_position),
      .rsp_run_end  (rsp_run_end)
   );
endmodule
